// ===== rtl/core/gd3_pkg.sv =====
// Shared types and constants of the 3x3 grayscale dilation block.
// Used by the channel interfaces, the window module and the top level.
// No dependencies.
package gd3_pkg;

  // Default sizes of the block.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Input word codes.
  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  // Border flags of the output position: which window row or column lies
  // outside the frame and must be left out of the maximum.
  typedef struct packed {
    logic skip_top;
    logic skip_bottom;
    logic skip_left;
    logic skip_right;
  } pos_flags_t;

endpackage

// ===== rtl/core/gd3_in_if.sv =====
// Input channel of the dilation block: valid/ready plus one pixel word.
// Depends on gd3_pkg for the default pixel width.
interface gd3_in_if #(
  parameter int PIXEL_BITS = gd3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output action, output pixel_value, input ready);
  modport sink   (input valid, input action, input pixel_value, output ready);
endinterface

// ===== rtl/core/gd3_out_if.sv =====
// Result channel of the dilation block: valid/ready plus one result word.
// Depends on gd3_pkg for the default pixel width.
interface gd3_out_if #(
  parameter int PIXEL_BITS = gd3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] dilated_value;
  logic                  frame_end;

  modport source (output valid, output dilated_value, output frame_end, input ready);
  modport sink   (input valid, input dilated_value, input frame_end, output ready);
endinterface

// ===== rtl/core/gd3_window.sv =====
// 3x3 window register and masked maximum of the dilation block.
// Depends on gd3_pkg for the border flag struct.
module gd3_window #(
  parameter int PIXEL_BITS = gd3_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic [PIXEL_BITS-1:0] col_up,
  input  logic [PIXEL_BITS-1:0] col_mid,
  input  logic [PIXEL_BITS-1:0] col_px,
  input  gd3_pkg::pos_flags_t   flags,
  output logic [PIXEL_BITS-1:0] max_value
);
  import gd3_pkg::*;

  logic [PIXEL_BITS-1:0] win_r   [3][3];
  logic [PIXEL_BITS-1:0] win_nxt [3][3];
  logic [PIXEL_BITS-1:0] masked  [3][3];
  logic [PIXEL_BITS-1:0] row_max [3];

  // Shift the window one column left and take in the new column on the right.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = col_up;
    win_nxt[1][2] = col_mid;
    win_nxt[2][2] = col_px;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (shift_en) begin
      win_r <= win_nxt;
    end
  end

  // Positions outside the frame count as zero.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && flags.skip_top) || (r == 2 && flags.skip_bottom) ||
            (c == 0 && flags.skip_left) || (c == 2 && flags.skip_right)) begin
          masked[r][c] = '0;
        end else begin
          masked[r][c] = win_r[r][c];
        end
      end
    end
  end

  // Maximum per row, then over the three rows.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_max[r] = (masked[r][0] > masked[r][1]) ? masked[r][0] : masked[r][1];
      row_max[r] = (masked[r][2] > row_max[r]) ? masked[r][2] : row_max[r];
    end
    max_value = (row_max[0] > row_max[1]) ? row_max[0] : row_max[1];
    max_value = (row_max[2] > max_value) ? row_max[2] : max_value;
  end

endmodule

// ===== rtl/core/grayscale_dilate_3x3.sv =====
// Streaming 3x3 grayscale dilation with zero padding at the frame border.
// Depends on gd3_pkg, gd3_in_if, gd3_out_if and gd3_window.
//
// Usage:
//   in_chan carries raster-order pixel words (action pixel) followed by
//   frame_width+1 flush words that drain the last results. out_chan carries
//   one dilated word per frame pixel; frame_end marks the frame's last one.
//   cfg_we/cfg_index/cfg_wdata write frame_width and frame_height; write them
//   only while the block is idle. Out-of-range sizes are clamped to 1..MAX.
//   The result for a pixel is produced by the word that arrives one row plus
//   one pixel later; once that word is accepted, the result passes the line
//   store read, then the window and maximum, and then shows on out_chan.
//   Throughput: one word per cycle unless out_chan stalls; the two line stores
//   are single-write, single-read memories touched once per word, forwarding
//   consecutive words on the same entry (one-pixel-wide rows, frame start).
//   Reset clears counters, the window and the pipeline; the line stores are
//   not cleared and hold no meaning until written.
//   When the receiver stalls, the output register holds its word and the
//   pipeline backs up; in_chan.ready falls once both stages are held behind it.
module grayscale_dilate_3x3 #(
  parameter int MAX_WIDTH  = gd3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gd3_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = gd3_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gd3_in_if.sink                         in_chan,
  gd3_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [gd3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gd3_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gd3_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int CWW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int CWH = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] frame_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the frame size into 1..MAX.
  logic [CWW-1:0] w_ext;
  logic [CWH-1:0] h_ext;
  logic [WW-1:0]  w;
  logic [RW-1:0]  h;
  logic [RW-1:0]  h_p1;

  always_comb begin
    w_ext = CWW'(frame_width_r);
    h_ext = CWH'(frame_height_r);
    if (w_ext == '0) begin
      w = WW'(1);
    end else if (w_ext > CWW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = w_ext[WW-1:0];
    end
    if (h_ext == '0) begin
      h = RW'(1);
    end else if (h_ext > CWH'(MAX_HEIGHT)) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = h_ext[RW-1:0];
    end
    h_p1 = h + RW'(1);
  end

  // Pipeline handshake: stage 1 (memory read), stage 2 (window), output.
  logic out_valid_r;
  logic s1_valid_r;
  logic s2_valid_r;
  logic s2_has_r;
  logic out_free;
  logic s2_go;
  logic s2_free;
  logic s1_go;
  logic s1_free;
  logic in_acc;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s2_go    = s2_valid_r && (!s2_has_r || out_free);
  assign s2_free  = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_go;
  assign in_acc   = in_chan.valid && s1_free;

  assign in_chan.ready = s1_free;

  // Column and row counters of the incoming word.
  logic [AW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [WW-1:0] col_w;
  logic [WW-1:0] col_p1;
  logic          col_nz;

  assign col_w  = WW'(col_r);
  assign col_p1 = col_w + WW'(1);
  assign col_nz = (col_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (row_r >= h_p1) begin
        col_r <= '0;
        row_r <= '0;
      end else if (col_p1 >= w) begin
        col_r <= '0;
        row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_p1[AW-1:0];
      end
    end
  end

  // Output position of this word: one row and one pixel behind the input.
  logic       has_res;
  logic       frame_last;
  pos_flags_t flags;

  always_comb begin
    if (col_nz) begin
      has_res           = (row_r >= RW'(1)) && (row_r <= h) && (col_w <= w);
      flags.skip_top    = (row_r == RW'(1));
      flags.skip_bottom = (row_r == h);
      flags.skip_left   = (col_w == WW'(1));
      flags.skip_right  = (col_w == w);
    end else begin
      has_res           = (row_r >= RW'(2)) && (row_r <= h_p1);
      flags.skip_top    = (row_r == RW'(2));
      flags.skip_bottom = (row_r == h_p1);
      flags.skip_left   = (w == WW'(1));
      flags.skip_right  = 1'b1;
    end
    frame_last = flags.skip_bottom && flags.skip_right;
  end

  logic [PIXEL_BITS-1:0] px_in;
  assign px_in = (in_chan.action == ACTION_FLUSH) ? '0 : in_chan.pixel_value;

  // Line stores: read at accept, written back when the word leaves stage 1.
  logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_up_r;
  logic [PIXEL_BITS-1:0] rd_mid_r;

  // Stage 1 payload.
  logic [AW-1:0]         s1_idx_r;
  logic [PIXEL_BITS-1:0] s1_px_r;
  logic                  s1_has_r;
  logic                  s1_last_r;
  pos_flags_t            s1_flags_r;
  logic                  s1_fwd_r;
  logic [PIXEL_BITS-1:0] s1_fwd_up_r;
  logic [PIXEL_BITS-1:0] s1_fwd_mid_r;
  logic [PIXEL_BITS-1:0] s1_up;
  logic [PIXEL_BITS-1:0] s1_mid;

  // A read that meets a write to the same entry in one cycle takes the
  // written words instead of the stale memory data.
  assign s1_up  = s1_fwd_r ? s1_fwd_up_r  : rd_up_r;
  assign s1_mid = s1_fwd_r ? s1_fwd_mid_r : rd_mid_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_up_r  <= upper_mem[col_r];
      rd_mid_r <= middle_mem[col_r];
    end
    if (s1_go) begin
      upper_mem[s1_idx_r]  <= s1_mid;
      middle_mem[s1_idx_r] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r     <= col_r;
      s1_px_r      <= px_in;
      s1_has_r     <= has_res;
      s1_last_r    <= frame_last;
      s1_flags_r   <= flags;
      s1_fwd_r     <= s1_go && (s1_idx_r == col_r);
      s1_fwd_up_r  <= s1_mid;
      s1_fwd_mid_r <= s1_px_r;
    end
  end

  // Stage 2: window holds the neighborhood of the word in this stage.
  logic                  s2_last_r;
  pos_flags_t            s2_flags_r;
  logic [PIXEL_BITS-1:0] win_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= 1'b1;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_has_r   <= s1_has_r;
      s2_last_r  <= s1_last_r;
      s2_flags_r <= s1_flags_r;
    end
  end

  gd3_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_go),
    .col_up    (s1_up),
    .col_mid   (s1_mid),
    .col_px    (s1_px_r),
    .flags     (s2_flags_r),
    .max_value (win_max)
  );

  // Output register.
  logic [PIXEL_BITS-1:0] out_value_r;
  logic                  out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && s2_has_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_has_r) begin
      out_value_r <= win_max;
      out_end_r   <= s2_last_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.dilated_value = out_value_r;
  assign out_chan.frame_end     = out_end_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the 3x3 grayscale dilation block.
// It drives raster-order pixel words and flush words, predicts every dilated word
// and checks each field. Depends on gd3_pkg, gd3_in_if, gd3_out_if and the top level.
module tb_top;
  import gd3_pkg::*;

  localparam int unsigned MAX_W          = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H          = MAX_HEIGHT_DEF;
  localparam int unsigned RANDOM_WORDS   = 1100;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 200;
  localparam int unsigned DIR_ROWS       = 23;

  // One predicted result word.
  typedef struct packed {
    logic [7:0] value;
    logic       frame_end;
  } dilated_word_t;

  // One row of the directed plan: either a frame size or an input word.
  typedef enum bit {ROW_SIZE, ROW_WORD} plan_kind_t;
  typedef struct packed {
    plan_kind_t  kind;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        action;
    logic [7:0]  pixel;
    bit          typed;
    logic [7:0]  want_value;
    logic        want_end;
  } plan_row_t;

  // Receiver stall patterns.
  typedef enum int unsigned {SINK_OPEN, SINK_QUARTER, SINK_COIN, SINK_BURSTY} sink_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gd3_in_if  pix_in ();
  gd3_out_if dil_out ();

  grayscale_dilate_3x3 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (pix_in),
    .out_chan  (dil_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: sizes, two line stores, the window and the raster position.
  logic [10:0]   width_reg  = FRAME_WIDTH_RST;
  logic [10:0]   height_reg = FRAME_HEIGHT_RST;
  logic [7:0]    upper_row  [MAX_W];
  logic [7:0]    middle_row [MAX_W];
  logic [7:0]    win        [3][3];
  int unsigned   col_pos = 0;
  int unsigned   row_pos = 0;

  dilated_word_t pending_dilations [$];
  plan_row_t     dir_plan [DIR_ROWS];

  int unsigned   error_count   = 0;
  int unsigned   words_sent    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   frames_closed = 0;
  int unsigned   burst_left    = 0;
  int unsigned   idle_cycles   = 0;

  sink_mode_t    stall_mode = SINK_OPEN;
  int unsigned   stall_span = 0;
  logic [15:0]   stall_tick = '0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Out-of-range sizes behave as the nearest legal size.
  function automatic int unsigned clamp_size(input logic [10:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Advance the predictor by one accepted word; returns 1 when a result is due.
  function automatic bit dilate_predict(input logic action, input logic [7:0] pixel,
                                        output dilated_word_t word);
    int unsigned w, h, idx, ocol;
    int          orow, r, c;
    logic [7:0]  px, up, mid, best;
    bit          has;
    w    = clamp_size(width_reg, MAX_W);
    h    = clamp_size(height_reg, MAX_H);
    px   = (action == ACTION_FLUSH) ? 8'd0 : pixel;
    idx  = col_pos % MAX_W;
    up   = upper_row[idx];
    mid  = middle_row[idx];
    has  = 1'b0;
    word = '0;
    upper_row[idx]  = mid;
    middle_row[idx] = px;

    // Shift the window left and load the new column.
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;

    // The window is centered one row and one pixel behind the current word.
    if (col_pos >= 1) begin
      orow = int'(row_pos) - 1;
      ocol = col_pos - 1;
    end else begin
      orow = int'(row_pos) - 2;
      ocol = w - 1;
    end

    // Maximum over the neighbors that lie inside the frame.
    if (orow >= 0 && orow < int'(h) && ocol < w) begin
      best = 8'd0;
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          if (!((r == 0 && orow == 0) || (r == 2 && orow == int'(h) - 1) ||
                (c == 0 && ocol == 0) || (c == 2 && ocol == w - 1)) && win[r][c] > best)
            best = win[r][c];
        end
      end
      word.value     = best;
      word.frame_end = (orow == int'(h) - 1 && ocol == w - 1);
      has            = 1'b1;
    end

    // Raster position; the drain row past the frame closes it.
    if (row_pos >= h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end else if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return has;
  endfunction

  // Gray levels: mostly uniform, with extremes and dim values mixed in.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2, 3:    return 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one word in bursts with random gaps, then record what it should produce.
  task automatic send_word(input logic action, input logic [7:0] pixel, input bit typed,
                           input logic [7:0] want_value, input logic want_end);
    int unsigned   gap;
    dilated_word_t word;
    bit            has;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_in.valid       <= 1'b1;
    pix_in.action      <= action;
    pix_in.pixel_value <= pixel;
    do @(posedge clk); while (!pix_in.ready);
    words_sent++;
    has = dilate_predict(action, pixel, word);
    if (typed) begin
      word.value     = want_value;
      word.frame_end = want_end;
      has            = 1'b1;
    end
    if (has) pending_dilations.push_back(word);
  endtask

  // Stop sending and let every outstanding result come out.
  task automatic settle_block();
    pix_in.valid <= 1'b0;
    while (pending_dilations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both size registers on consecutive edges.
  task automatic set_frame_size(input logic [10:0] w, input logic [10:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we     <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  // Run whole frames at one size, with stray action codes and, when allowed,
  // drains that are cut short or run long; then close the open frame.
  task automatic run_frames(input logic [10:0] w_reg, input logic [10:0] h_reg,
                            input int unsigned frames, input bit allow_broken);
    int unsigned w, h, drain;
    w = clamp_size(w_reg, MAX_W);
    h = clamp_size(h_reg, MAX_H);
    settle_block();
    set_frame_size(w_reg, h_reg);
    repeat (frames) begin
      repeat (w * h)
        send_word(($urandom_range(0, 19) == 0) ? ACTION_FLUSH : ACTION_PIXEL,
                  pick_pixel(), 1'b0, 8'd0, 1'b0);
      drain = w + 1;
      if (allow_broken && $urandom_range(0, 4) == 0) drain = $urandom_range(0, w + 3);
      repeat (drain)
        send_word(($urandom_range(0, 9) == 0) ? ACTION_PIXEL : ACTION_FLUSH,
                  pick_pixel(), 1'b0, 8'd0, 1'b0);
    end
    while (col_pos != 0 || row_pos != 0)
      send_word(ACTION_FLUSH, pick_pixel(), 1'b0, 8'd0, 1'b0);
  endtask

  // Stimulus.
  initial begin
    int unsigned random_start;
    logic [10:0] w_pick, h_pick;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_FRAME_WIDTH;
    cfg_wdata          <= '0;
    pix_in.valid       <= 1'b0;
    pix_in.action      <= ACTION_PIXEL;
    pix_in.pixel_value <= '0;
    for (int i = 0; i < int'(MAX_W); i++) begin
      upper_row[i]  = 8'd0;
      middle_row[i] = 8'd0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = 8'd0;

    // Directed plan. Sizes of zero act as one; the 3x2 frame carries a flush
    // word inside the frame and a pixel word inside the drain.
    dir_plan = '{
      '{ROW_SIZE, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd255, 1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd0,   1'b1, 8'd255, 1'b1},
      '{ROW_SIZE, 11'd3, 11'd2, ACTION_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd255, 1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b1, 8'd255, 1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b1, 8'd255, 1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd0,   1'b1, 8'd255, 1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd200, 1'b1, 8'd255, 1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd0,   1'b1, 8'd255, 1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd0,   1'b1, 8'd255, 1'b1},
      '{ROW_SIZE, 11'd2, 11'd2, ACTION_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_PIXEL, 8'd0,   1'b1, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd0,   1'b1, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd0,   1'b1, 8'd0,   1'b0},
      '{ROW_WORD, 11'd0, 11'd0, ACTION_FLUSH, 8'd0,   1'b1, 8'd0,   1'b1}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_SIZE) begin
        settle_block();
        set_frame_size(dir_plan[i].width_reg, dir_plan[i].height_reg);
      end else begin
        send_word(dir_plan[i].action, dir_plan[i].pixel, dir_plan[i].typed,
                  dir_plan[i].want_value, dir_plan[i].want_end);
      end
    end

    // Random phases, mostly small frames.
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0:       w_pick = 11'($urandom_range(0, 1));
        7, 8:    w_pick = 11'($urandom_range(9, 32));
        9:       w_pick = 11'($urandom_range(33, 64));
        default: w_pick = 11'($urandom_range(2, 8));
      endcase
      h_pick = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1))
                                          : 11'($urandom_range(2, 6));
      run_frames(w_pick, h_pick, $urandom_range(1, 3), 1'b1);
    end

    settle_block();
    $display("Sent %0d words: directed frames, then random frame sizes and drains.",
             words_sent);
    $display("Checked %0d dilated words across %0d completed frames.",
             results_seen, frames_closed);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: switches at random between stall patterns.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_span == 0) begin
      stall_mode <= sink_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(32, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      SINK_OPEN:    dil_out.ready <= 1'b1;
      SINK_QUARTER: dil_out.ready <= (stall_tick[1:0] == 2'b00);
      SINK_COIN:    dil_out.ready <= 1'($urandom_range(0, 1));
      default:      dil_out.ready <= (stall_tick[3:0] < 4'd10);
    endcase
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    dilated_word_t want;
    if (rst_n && dil_out.valid && dil_out.ready) begin
      results_seen++;
      if (dil_out.frame_end === 1'b1) frames_closed++;
      if (pending_dilations.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected word: expected none, got value %0d frame_end %0b",
                   $time, dil_out.dilated_value, dil_out.frame_end);
      end else begin
        want = pending_dilations.pop_front();
        if (dil_out.dilated_value !== want.value) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: dilated_value mismatch: expected %0d, got %0d",
                     $time, want.value, dil_out.dilated_value);
        end
        if (dil_out.frame_end !== want.frame_end) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: frame_end mismatch: expected %0b, got %0b",
                     $time, want.frame_end, dil_out.frame_end);
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_in.valid && pix_in.ready) || (dil_out.valid && dil_out.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results still outstanding",
                 $time, idle_cycles, pending_dilations.size());
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ===== grayscale_dilate_3x3.f =====
rtl/core/gd3_pkg.sv
rtl/core/gd3_in_if.sv
rtl/core/gd3_out_if.sv
rtl/core/gd3_window.sv
rtl/core/grayscale_dilate_3x3.sv
tb/sv/tb_top.sv
